>>> design/assert_macros.svh
// Assertion macros for the checker file of the text-to-LCD block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, quiet while rst is high.
`define TXTLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define TXTLCD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/txtlcd_pkg.sv
// Package: types, command codes and register indexes of the text-to-LCD block.
package txtlcd_pkg;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW_STRIDE   = 8'h40;
  // Row 1 is the only row a set-address command ever points at.
  localparam logic [7:0] ADDR_ROW1    = CMD_SET_ADDR + ROW_STRIDE;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [1:0] LINE_COUNT_RESET = 2'd2;
  localparam logic [5:0] LINE_WIDTH_RESET = 6'd16;
  localparam logic [5:0] LINE_WIDTH_MAX   = 6'd40;

  typedef enum logic {
    REG_LINE_COUNT = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } reg_index_t;

  // One controller write.
  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
  } entry_t;

  // Results of one text byte, packed from slot 0 up, cnt of them valid.
  typedef struct packed {
    entry_t [2:0] slot;
    logic   [1:0] cnt;
  } batch_t;

endpackage

>>> design/txtlcd_layout.sv
// Cursor state and per-byte layout decision: row, column, finished flag.
module txtlcd_layout import txtlcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] character,
  input  logic       start_of_text,
  input  logic [1:0] line_count,
  input  logic [5:0] line_width,
  output batch_t     batch
);

  logic       row, row_next;
  logic [5:0] column, column_next;
  logic       finished, finished_next;

  logic       rows_two;
  logic [5:0] width;
  logic       row_c, fin_a;
  logic [5:0] col_c, col_inc;
  logic       emit_clr, emit_dat, emit_adr;
  logic       want_next_row;
  entry_t     e_clr, e_dat, e_adr;

  always_comb begin
    rows_two = (line_count >= 2'd2);
    if (line_width == 6'd0) begin
      width = 6'd1;
    end else if (line_width > LINE_WIDTH_MAX) begin
      width = LINE_WIDTH_MAX;
    end else begin
      width = line_width;
    end

    emit_clr = start_of_text;
    row_c    = start_of_text ? 1'b0 : row;
    col_c    = start_of_text ? 6'd0 : column;
    // Row held past the row count ends the text.
    fin_a    = (start_of_text ? 1'b0 : finished) | (row_c & ~rows_two);
    col_inc  = col_c + 6'd1;

    emit_dat      = 1'b0;
    emit_adr      = 1'b0;
    want_next_row = 1'b0;
    row_next      = row_c;
    column_next   = col_c;
    finished_next = fin_a;

    if (!fin_a) begin
      case (character)
        CH_NUL: finished_next = 1'b1;
        CH_CR:  ;
        CH_LF:  want_next_row = 1'b1;
        default: begin
          emit_dat      = 1'b1;
          column_next   = col_inc;
          want_next_row = (col_inc >= width);
        end
      endcase
    end

    if (want_next_row) begin
      if (row_c | ~rows_two) begin
        finished_next = 1'b1;
      end else begin
        row_next    = 1'b1;
        column_next = 6'd0;
        emit_adr    = 1'b1;
      end
    end
  end

  // Pack the results in order: clear, data, set-address.
  always_comb begin
    e_clr = '{is_data: 1'b0, lcd_byte: CMD_CLEAR};
    e_dat = '{is_data: 1'b1, lcd_byte: character};
    e_adr = '{is_data: 1'b0, lcd_byte: ADDR_ROW1};
    batch.slot[0] = emit_clr ? e_clr : (emit_dat ? e_dat : e_adr);
    batch.slot[1] = (emit_clr && emit_dat) ? e_dat : e_adr;
    batch.slot[2] = e_adr;
    batch.cnt     = 2'({1'b0, emit_clr} + {1'b0, emit_dat} + {1'b0, emit_adr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= 1'b0;
      column   <= 6'd0;
      finished <= 1'b0;
    end else if (accept) begin
      row      <= row_next;
      column   <= column_next;
      finished <= finished_next;
    end
  end

endmodule

>>> design/txtlcd_outbuf.sv
// Result register: holds up to three writes of one byte and sends them one per beat.
module txtlcd_outbuf import txtlcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  batch_t     batch,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output entry_t     out_entry,
  output logic       out_last
);

  entry_t [2:0] slot;
  logic   [1:0] cnt;
  logic         pop;

  assign out_valid = (cnt != 2'd0);
  assign out_entry = slot[0];
  assign out_last  = (cnt == 2'd1);
  assign pop       = out_valid & out_ready;
  // Free now, or the last held beat leaves this cycle.
  assign in_ready  = (cnt == 2'd0) | (out_last & out_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= batch.slot;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= batch.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

endmodule

>>> design/text_to_lcd_command_stream_top.sv
// Top level of the text-to-LCD command stream block.
//
// Use: feed text one byte per beat on s_axis (tdata = character, tuser =
// start_of_text). Each byte yields zero to three controller writes on
// m_axis: tdata = byte to write, tuser = 1 for a data write, 0 for a
// command, tlast = 1 on the final write caused by that text byte.
// A start-of-text byte first yields the clear command; any byte but NUL,
// CR and LF a data write; a line feed or full row on row 0 with two rows
// a set-address to row 1. Carriage returns and bytes after the end of
// the text yield nothing. An accepted byte's first write shows next cycle.
// Throughput: one byte per cycle while each yields at most one write and
// m_axis_tready is high; the single result register drains one beat per
// ready cycle and holds the input until its last held write leaves.
// Stall: when m_axis_tready is low the held write stays put, and s_axis
// takes the next byte only in the cycle the last held write leaves.
// Reset (rst, synchronous): drops any held writes, cursor to row 0,
// column 0, two rows of sixteen characters.
// cfg_we/cfg_index/cfg_data: index 0 = line_count, 1 = line_width; write
// only while the block is idle.
module text_to_lcd_command_stream_top import txtlcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] character
  input  logic       s_axis_tuser,   // [0] start_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] lcd_byte
  output logic       m_axis_tuser,   // [0] is_data
  output logic       m_axis_tlast,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);

  logic [1:0] line_count;
  logic [5:0] line_width;
  logic       accept;
  batch_t     batch;
  entry_t     out_entry;

  // Configuration registers; upper bits of a narrow register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= LINE_COUNT_RESET;
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LINE_COUNT: line_count <= cfg_data[1:0];
        REG_LINE_WIDTH: line_width <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  // Decide the writes for the byte on the input and advance the cursor.
  txtlcd_layout u_layout (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .character     (s_axis_tdata),
    .start_of_text (s_axis_tuser),
    .line_count    (line_count),
    .line_width    (line_width),
    .batch         (batch)
  );

  // Hold the writes and hand them out one beat at a time.
  txtlcd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch     (batch),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_entry (out_entry),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = out_entry.lcd_byte;
  assign m_axis_tuser = out_entry.is_data;

endmodule

>>> design/txtlcd_checker.sv
// Port-level checker for the text-to-LCD block, bound to the top level.
`include "assert_macros.svh"

module txtlcd_checker import txtlcd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled beat holds.
  `TXTLCD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output beat changed")

  // With nothing held the input side is open.
  `TXTLCD_ASSERT(a_idle_ready, !m_axis_tvalid |-> s_axis_tready, "input blocked with no beat held")

  // A start-of-text byte leads with the clear command.
  `TXTLCD_ASSERT(a_clear_first, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> m_axis_tvalid && !m_axis_tuser && m_axis_tdata == CMD_CLEAR, "clear not sent first")

  // Commands are clear or the row 1 address only.
  `TXTLCD_ASSERT(a_cmd_codes, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == CMD_CLEAR || m_axis_tdata == ADDR_ROW1, "unexpected command byte")

  // Last beat taken and no new byte: output goes idle.
  `TXTLCD_ASSERT(a_drain_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid, "beat after tlast without input")

endmodule

bind text_to_lcd_command_stream_top txtlcd_checker u_txtlcd_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the text-to-LCD command stream block.
module tb_top import txtlcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles to let pass once every write is back: room for the result register
  // and for a byte that yields nothing.
  localparam int SETTLE_CYCLES = 4;

  // One controller write as the block should produce it.
  typedef struct {
    logic       is_data;
    logic [7:0] code;
    logic       last;
  } lcd_write_t;

  // Tracks cursor state and configuration, predicts the writes of every
  // accepted text byte and checks the writes that leave the block in order.
  class lcd_write_board;
    logic [1:0] line_count;
    logic [5:0] line_width;
    logic       row;
    logic [5:0] column;
    logic       finished;
    lcd_write_t writes_due[$];
    lcd_write_t fresh[$];
    int         mismatches;

    function new();
      line_count = LINE_COUNT_RESET;
      line_width = LINE_WIDTH_RESET;
      row        = 1'b0;
      column     = '0;
      finished   = 1'b0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endfunction

    // Out-of-range register values fold onto the nearest legal setting.
    function int rows_in_use();
      if (line_count == 2'd0) return 1;
      if (line_count > 2'd2) return 2;
      return int'(line_count);
    endfunction

    function int width_in_use();
      if (line_width == 6'd0) return 1;
      if (line_width > LINE_WIDTH_MAX) return int'(LINE_WIDTH_MAX);
      return int'(line_width);
    endfunction

    function void set_config(reg_index_t idx, logic [5:0] value);
      if (idx == REG_LINE_COUNT) line_count = value[1:0];
      else line_width = value;
    endfunction

    function void push_write(logic is_data, logic [7:0] code);
      lcd_write_t w;
      w.is_data = is_data;
      w.code    = code;
      w.last    = 1'b0;
      fresh.push_back(w);
    endfunction

    // Line feed or full row: step to the next row, or end the text on the last one.
    function void advance_row(int rows);
      if (int'(row) + 1 >= rows) begin
        finished = 1'b1;
        return;
      end
      row    = 1'b1;
      column = '0;
      push_write(1'b0, CMD_SET_ADDR + ROW_STRIDE);
    endfunction

    // Predict the writes of one text byte; returns how many it yields.
    function int note_char(logic [7:0] ch, logic sot);
      int rows;
      int width;
      int n;
      rows  = rows_in_use();
      width = width_in_use();
      fresh.delete();
      if (sot) begin
        push_write(1'b0, CMD_CLEAR);
        row      = 1'b0;
        column   = '0;
        finished = 1'b0;
      end
      // A row count lowered under the held row ends the text.
      if (!finished && int'(row) >= rows) finished = 1'b1;
      if (!finished) begin
        if (ch == CH_NUL) begin
          finished = 1'b1;
        end else if (ch == CH_LF) begin
          advance_row(rows);
        end else if (ch != CH_CR) begin
          push_write(1'b1, ch);
          column = column + 6'd1;
          if (int'(column) >= width) advance_row(rows);
        end
      end
      n = fresh.size();
      if (n > 0) fresh[n-1].last = 1'b1;
      foreach (fresh[i]) writes_due.push_back(fresh[i]);
      return n;
    endfunction

    function void check_write(logic is_data, logic [7:0] code, logic last);
      lcd_write_t w;
      if (writes_due.size() == 0) begin
        flag($sformatf("write with nothing due: is_data=%0b byte=%02h last=%0b",
                       is_data, code, last));
        return;
      end
      w = writes_due.pop_front();
      if (is_data !== w.is_data)
        flag($sformatf("is_data %0b, want %0b (byte %02h)", is_data, w.is_data, w.code));
      if (code !== w.code)
        flag($sformatf("lcd_byte %02h, want %02h", code, w.code));
      if (last !== w.last)
        flag($sformatf("last %0b, want %0b (byte %02h)", last, w.last, w.code));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;

  lcd_write_board sb = new();

  int send_idle_pct = 27;
  int recv_idle_pct = 58;
  int fed;     // accepted bytes
  int cycles;

  text_to_lcd_command_stream_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_write(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one text byte and hold it until the block takes it. Valid stays
  // high afterwards so back-to-back beats need no extra assignment.
  task automatic send_char(input logic [7:0] ch, input logic sot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= sot;
    do @(posedge clk); while (!s_axis_tready);
    void'(sb.note_char(ch, sot));
    fed++;
  endtask

  // Drop valid and let every due write drain before touching registers.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_config(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly printable content with line feeds, carriage returns, an
  // occasional terminator and now and then any byte at all.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(8'h20, 8'h7e));
    if (r < 80) return CH_LF;
    if (r < 86) return CH_CR;
    if (r < 89) return CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  // A text: start marker, then up to enough bytes to fill and overrun a
  // two-row screen, cut to max_len bytes.
  task automatic send_text(input int max_len);
    int len;
    len = $urandom_range(1, 2 * sb.width_in_use() + 4);
    if (len > max_len) len = max_len;
    send_char(pick_char(), 1'b1);
    for (int i = 1; i < len; i++)
      send_char(pick_char(), ($urandom_range(39) == 0));
  endtask

  // Settings walked by the random part, extremes and out-of-range codes included.
  int unsigned row_codes[9]   = '{1, 2, 2, 0, 3, 2, 1, 2, 3};
  int unsigned width_codes[9] = '{1, 1, 40, 3, 0, 63, 8, 5, 41};

  initial begin
    int budget;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset setting of two rows of sixteen.
    send_char("A", 1'b0);          // byte ahead of any start marker
    send_char("H", 1'b1);          // clear, then data
    send_char(8'hff, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(CH_CR, 1'b0);        // carriage return: nothing
    send_char(CH_LF, 1'b0);        // address of row 1
    send_char("x", 1'b0);
    send_char(CH_LF, 1'b0);        // line feed on the last row ends the text
    send_char("y", 1'b0);          // dropped
    send_char(CH_NUL, 1'b1);       // clear, then terminator
    send_char("z", 1'b0);          // dropped after the terminator
    send_char(CH_CR, 1'b1);
    send_char(CH_LF, 1'b1);        // clear plus address command
    send_char(8'h80, 1'b0);

    // One character per row: clear, data and wrap from a single byte.
    wait_idle();
    write_reg(REG_LINE_WIDTH, 6'd1);
    send_char("c", 1'b1);
    send_char("d", 1'b0);          // wrap on the last row ends the text
    send_char("e", 1'b0);
    send_char("f", 1'b1);

    // Row count lowered under the held row: the next byte is dropped.
    wait_idle();
    write_reg(REG_LINE_COUNT, 6'd1);
    send_char("g", 1'b0);

    // Width lowered under the held column: the next data byte wraps at once.
    wait_idle();
    write_reg(REG_LINE_COUNT, 6'd2);
    write_reg(REG_LINE_WIDTH, LINE_WIDTH_MAX);
    send_char("h", 1'b1);
    send_char("i", 1'b0);
    send_char("j", 1'b0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 6'd2);
    send_char("k", 1'b0);
    send_char(8'h55, 1'b0);

    // Random part: three idling modes, three settings each.
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      case (p / 3)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(REG_LINE_COUNT, 6'(row_codes[p]));
      write_reg(REG_LINE_WIDTH, 6'(width_codes[p]));
      // The wide setting gets room for one text that wraps a full row.
      budget = fed + ((p == 2) ? 44 : 6);
      while (fed < budget) begin
        // Noise: stray bytes that may continue the text held across the write.
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 3))
            send_char(8'($urandom_range(255)), ($urandom_range(3) == 0));
        end else begin
          send_text(budget - fed);
        end
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.writes_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/txtlcd_pkg.sv
design/txtlcd_layout.sv
design/txtlcd_outbuf.sv
design/text_to_lcd_command_stream_top.sv
design/txtlcd_checker.sv
verif/tb_top.sv
